// ----- hw/rtl/ghb_pkg.sv -----
// ----------------------------------------------------------------------------
// ghb_pkg
// Shared types and constants for the GHASH block accumulator.
// ----------------------------------------------------------------------------
package ghb_pkg;

    localparam int BLOCK_W    = 128;
    localparam int HALF_W     = 64;
    localparam int BYTES      = 16;
    localparam int BITS_STEP  = 8;
    localparam int STEPS      = BLOCK_W / BITS_STEP;
    localparam int COUNT_W    = $clog2(STEPS);
    localparam int CFG_IDX_W  = 1;

    // reduction constant 0x87, bit-reflected into the top byte
    localparam logic [7:0] GHASH_R = 8'hE1;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOWER = 1'b1;

    typedef struct packed {
        logic [63:0] block_upper;
        logic [63:0] block_lower;
        logic [4:0]  valid_bytes;
        logic        restart;
        logic        final_block;
    } ghb_in_t;

    typedef struct packed {
        logic [63:0] digest_upper;
        logic [63:0] digest_lower;
        logic        digest_final;
    } ghb_out_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic push;
    } ghb_cmd_t;

endpackage

// ----- hw/rtl/ghash_block_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// ghash_block_accumulator_top
// GCM GHASH accumulator: digest = (digest ^ block) * H per data word.
// ----------------------------------------------------------------------------
// An accepted word is multiplied by H in the 8-bit-per-cycle multiplier and
//   then handed off; a new word is accepted only after that handoff, which
//   waits while an earlier digest word is still held for out_ready
// reset: asynchronous, clears key, accumulator and all handshake state
// ----------------------------------------------------------------------------
module ghash_block_accumulator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  ghb_pkg::ghb_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ghb_pkg::ghb_out_t               out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ghb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ghb_pkg::HALF_W-1:0]      cfg_data
);
    import ghb_pkg::*;

    ghb_cmd_t cmd;

    assign cfg_ready = 1'b1;

    ghb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ghb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while multiply in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step, cmd.push}))
        else $error("conflicting datapath commands");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> out_valid)
        else $error("handoff did not raise out_valid");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (!in_ready && !cmd.step))
        else $error("multiply ran past its last step");

endmodule

// ----- hw/rtl/ghb_ctrl.sv -----
// ----------------------------------------------------------------------------
// ghb_ctrl
// Sequencer: accepts a word, runs sixteen multiply steps, hands off result.
// ----------------------------------------------------------------------------
module ghb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output ghb_pkg::ghb_cmd_t cmd
);
    import ghb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.step   = (state_reg == ST_MUL);
        cmd.finish = (state_reg == ST_MUL) && (count_reg == COUNT_W'(STEPS - 1));
        cmd.push   = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    count_next = '0;
                end
            end
            ST_MUL:
            begin
                count_next = count_reg + COUNT_W'(1);
                if (cmd.finish)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (cmd.push)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/ghb_datapath.sv -----
// ----------------------------------------------------------------------------
// ghb_datapath
// Key, accumulator and an 8-bit-per-step GF(2^128) shift-and-add multiplier.
// ----------------------------------------------------------------------------
module ghb_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ghb_pkg::ghb_cmd_t               cmd,
    input  ghb_pkg::ghb_in_t                in_data,
    input  logic                            cfg_we,
    input  logic [ghb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ghb_pkg::HALF_W-1:0]      cfg_data,
    output ghb_pkg::ghb_out_t               out_data
);
    import ghb_pkg::*;

    logic [HALF_W-1:0]  key_upper_reg, key_lower_reg;
    logic [BLOCK_W-1:0] acc_reg, acc_next;
    logic [BLOCK_W-1:0] x_reg, x_next;
    logic [BLOCK_W-1:0] v_reg, v_next;
    logic [BLOCK_W-1:0] r_reg, r_next;
    logic               fin_reg;
    ghb_out_t           out_reg;
    logic [BLOCK_W-1:0] mask;
    logic [BLOCK_W-1:0] data_masked;

    // zero-pad past the valid byte count
    always_comb
    begin
        for (int b = 0; b < BYTES; b++)
        begin
            mask[BLOCK_W-1-8*b -: 8] = (5'(b) < in_data.valid_bytes) ? 8'hFF : 8'h00;
        end
        data_masked = {in_data.block_upper, in_data.block_lower} & mask;
    end

    // eight multiply bit-steps per cycle, applied to x, v and r only when cmd.step
    always_comb
    begin
        logic [BLOCK_W-1:0] rr;
        logic [BLOCK_W-1:0] vv;
        logic               lsb;
        rr = r_reg;
        vv = v_reg;
        for (int j = 0; j < BITS_STEP; j++)
        begin
            if (x_reg[BLOCK_W-1-j])
            begin
                rr = rr ^ vv;
            end
            lsb = vv[0];
            vv  = vv >> 1;
            if (lsb)
            begin
                vv[BLOCK_W-1 -: 8] = vv[BLOCK_W-1 -: 8] ^ GHASH_R;
            end
        end
        r_next = rr;
        v_next = vv;
        x_next = x_reg << BITS_STEP;
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.finish)
        begin
            acc_next = r_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            if (cfg_we && (cfg_index == CFG_KEY_UPPER))
            begin
                key_upper_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_KEY_LOWER))
            begin
                key_lower_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg   <= (in_data.restart ? '0 : acc_reg) ^ data_masked;
            v_reg   <= {key_upper_reg, key_lower_reg};
            r_reg   <= '0;
            fin_reg <= in_data.final_block;
        end
        else if (cmd.step)
        begin
            x_reg <= x_next;
            v_reg <= v_next;
            r_reg <= r_next;
        end
        if (cmd.push)
        begin
            out_reg.digest_upper <= acc_reg[BLOCK_W-1 -: HALF_W];
            out_reg.digest_lower <= acc_reg[HALF_W-1:0];
            out_reg.digest_final <= fin_reg;
        end
    end

    assign out_data = out_reg;

endmodule
